[sv/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and character constants for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int CHAR_BITS    = 16;
   localparam int OUT_POS_BITS = 24;

   localparam logic [CHAR_BITS-1:0] CH_HASH    = 16'h0023;
   localparam logic [CHAR_BITS-1:0] CH_BAR     = 16'h007C;
   localparam logic [CHAR_BITS-1:0] CH_NL      = 16'h000A;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE   = 16'h0022;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH  = 16'h005C;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN  = 16'h0028;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN  = 16'h0029;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE  = 16'h007B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE  = 16'h007D;
   localparam logic [CHAR_BITS-1:0] CH_LBRACK  = 16'h005B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACK  = 16'h005D;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_STRING = 2'd1,
      MODE_LINE   = 2'd2,
      MODE_BLOCK  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_HASH = 2'd1,
      PEND_BAR  = 2'd2,
      PEND_ESC  = 2'd3
   } pend_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_OPEN_COMMENT  = 4'd1,
      ERR_EXTRA_PAREN   = 4'd2,
      ERR_EXTRA_BRACE   = 4'd3,
      ERR_EXTRA_BRACKET = 4'd4,
      ERR_OPEN_STRING   = 4'd5,
      ERR_OPEN_BRACE    = 4'd6,
      ERR_OPEN_PAREN    = 4'd7,
      ERR_OPEN_BRACKET  = 4'd8
   } err_type;

endpackage

[sv/bracket_balance_checker.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streams script text one character per transaction and reports whether
// parentheses, braces, brackets, strings and nested block comments balance.
//
// Usage:
//   req_ channel: one character (req_ch) per transaction, req_last marks the
//   final character of a script. rsp_ channel: one transaction per script,
//   carrying rsp_ok, rsp_error_code and the error position (rsp_line,
//   rsp_column; zero when ok).
//   Throughput is one character per cycle while req_ready is high; the
//   scanner state is updated in the cycle a character is taken. The result is
//   registered and appears in the cycle after the last character is accepted.
//   The result register separates the two sides: req_ready stays high while
//   the register is empty or being drained, and drops only while a result
//   is held by a stalled receiver.
//   The first unmatched closer freezes the scan; later characters are taken
//   and ignored until the last one. After each result, and at reset, the
//   scanner returns to line 1, column 1 with all depths cleared.
// ----------------------------------------------------------------------------
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int DEPTH_BITS = 16,
   parameter int POS_BITS   = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CHAR_BITS-1:0]    req_ch,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_ok,
   output logic [3:0]              rsp_error_code,
   output logic [OUT_POS_BITS-1:0] rsp_line,
   output logic [OUT_POS_BITS-1:0] rsp_column
);

   localparam int WIDE_BITS = (POS_BITS > OUT_POS_BITS) ? POS_BITS : OUT_POS_BITS;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [POS_BITS-1:0]   POS_ONE   = POS_BITS'(1);

   mode_type              mode_ff, mode_in;
   pend_type              pend_ff, pend_in;
   logic [DEPTH_BITS-1:0] paren_ff, paren_in;
   logic [DEPTH_BITS-1:0] brace_ff, brace_in;
   logic [DEPTH_BITS-1:0] brack_ff, brack_in;
   logic [DEPTH_BITS-1:0] cdepth_ff, cdepth_in;
   logic [POS_BITS-1:0]   line_ff, line_in;
   logic [POS_BITS-1:0]   col_ff, col_in;
   err_type               err_ff, err_in;
   logic [POS_BITS-1:0]   eline_ff, eline_in;
   logic [POS_BITS-1:0]   ecol_ff, ecol_in;

   logic                  rsp_valid_ff;
   err_type               rsp_code_ff, rsp_code_in;
   logic [POS_BITS-1:0]   rsp_line_ff, rsp_line_in;
   logic [POS_BITS-1:0]   rsp_col_ff, rsp_col_in;

   logic                  req_take;
   logic [1:0]            inc_pre;
   logic [1:0]            inc_post;
   logic [1:0]            inc_end;
   logic                  newline;
   logic                  done;
   logic [DEPTH_BITS-1:0] cdepth_dec;
   logic [POS_BITS-1:0]   col_mid;
   logic [POS_BITS-1:0]   col_end;
   logic [WIDE_BITS-1:0]  line_wide;
   logic [WIDE_BITS-1:0]  col_wide;

   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                   input logic [1:0] n);
      logic [POS_BITS:0] s;
      s = {1'b0, a} + (POS_BITS+1)'(n);
      return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
   endfunction

   function automatic logic [DEPTH_BITS-1:0] depth_up(input logic [DEPTH_BITS-1:0] d);
      return (d == DEPTH_MAX) ? d : d + DEPTH_BITS'(1);
   endfunction

   assign req_take  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      paren_in   = paren_ff;
      brace_in   = brace_ff;
      brack_in   = brack_ff;
      cdepth_in  = cdepth_ff;
      err_in     = err_ff;
      eline_in   = eline_ff;
      ecol_in    = ecol_ff;
      inc_pre    = 2'd0;
      inc_post   = 2'd0;
      newline    = 1'b0;
      done       = 1'b0;
      cdepth_dec = (cdepth_ff != '0) ? cdepth_ff - DEPTH_BITS'(1) : cdepth_ff;

      if (err_ff == ERR_NONE) begin
         case (pend_ff)
            PEND_ESC: begin
               pend_in = PEND_NONE;
               inc_pre = 2'd2;
               done    = 1'b1;
            end
            PEND_HASH: begin
               pend_in = PEND_NONE;
               if (req_ch == CH_BAR) begin
                  inc_pre = 2'd2;
                  done    = 1'b1;
                  if (mode_ff == MODE_BLOCK) begin
                     cdepth_in = depth_up(cdepth_ff);
                  end else begin
                     mode_in   = MODE_BLOCK;
                     cdepth_in = DEPTH_BITS'(1);
                  end
               end else begin
                  inc_pre = 2'd1;
                  if (mode_ff == MODE_NORMAL) begin
                     mode_in = MODE_LINE;
                  end
               end
            end
            PEND_BAR: begin
               pend_in = PEND_NONE;
               if (req_ch == CH_HASH) begin
                  inc_pre   = 2'd2;
                  done      = 1'b1;
                  cdepth_in = cdepth_dec;
                  if (cdepth_dec == '0) begin
                     mode_in = MODE_NORMAL;
                  end
               end else begin
                  inc_pre = 2'd1;
               end
            end
            default: ;
         endcase

         if (!done) begin
            if (req_ch == CH_NL) begin
               newline = 1'b1;
               if (mode_in == MODE_LINE) begin
                  mode_in = MODE_NORMAL;
               end
            end else begin
               case (mode_in)
                  MODE_LINE: inc_post = 2'd1;
                  MODE_BLOCK: begin
                     if (req_ch == CH_HASH) begin
                        pend_in = PEND_HASH;
                     end else if (req_ch == CH_BAR) begin
                        pend_in = PEND_BAR;
                     end else begin
                        inc_post = 2'd1;
                     end
                  end
                  MODE_STRING: begin
                     if (req_ch == CH_BSLASH) begin
                        pend_in = PEND_ESC;
                     end else begin
                        if (req_ch == CH_QUOTE) begin
                           mode_in = MODE_NORMAL;
                        end
                        inc_post = 2'd1;
                     end
                  end
                  default: begin
                     case (req_ch)
                        CH_HASH: pend_in = PEND_HASH;
                        CH_QUOTE: begin
                           mode_in  = MODE_STRING;
                           inc_post = 2'd1;
                        end
                        CH_LPAREN: begin
                           paren_in = depth_up(paren_ff);
                           inc_post = 2'd1;
                        end
                        CH_LBRACE: begin
                           brace_in = depth_up(brace_ff);
                           inc_post = 2'd1;
                        end
                        CH_LBRACK: begin
                           brack_in = depth_up(brack_ff);
                           inc_post = 2'd1;
                        end
                        CH_RPAREN: begin
                           if (paren_ff == '0) begin
                              err_in = ERR_EXTRA_PAREN;
                           end else begin
                              paren_in = paren_ff - DEPTH_BITS'(1);
                              inc_post = 2'd1;
                           end
                        end
                        CH_RBRACE: begin
                           if (brace_ff == '0) begin
                              err_in = ERR_EXTRA_BRACE;
                           end else begin
                              brace_in = brace_ff - DEPTH_BITS'(1);
                              inc_post = 2'd1;
                           end
                        end
                        CH_RBRACK: begin
                           if (brack_ff == '0) begin
                              err_in = ERR_EXTRA_BRACKET;
                           end else begin
                              brack_in = brack_ff - DEPTH_BITS'(1);
                              inc_post = 2'd1;
                           end
                        end
                        default: inc_post = 2'd1;
                     endcase
                  end
               endcase
            end
         end
      end

      col_mid = sat_add(col_ff, inc_pre);
      if (err_in != err_ff) begin
         eline_in = line_ff;
         ecol_in  = col_mid;
      end

      if (newline) begin
         line_in = sat_add(line_ff, 2'd1);
         col_in  = POS_ONE;
      end else begin
         line_in = line_ff;
         col_in  = sat_add(col_mid, inc_post);
      end

      case (pend_in)
         PEND_ESC:  inc_end = 2'd2;
         PEND_NONE: inc_end = 2'd0;
         default:   inc_end = 2'd1;
      endcase
      col_end = sat_add(col_in, inc_end);

      rsp_line_in = line_in;
      rsp_col_in  = col_end;
      if (err_in != ERR_NONE) begin
         rsp_code_in = err_in;
         rsp_line_in = eline_in;
         rsp_col_in  = ecol_in;
      end else if (mode_in == MODE_BLOCK) begin
         rsp_code_in = ERR_OPEN_COMMENT;
      end else if (mode_in == MODE_STRING) begin
         rsp_code_in = ERR_OPEN_STRING;
      end else if (brace_in != '0) begin
         rsp_code_in = ERR_OPEN_BRACE;
      end else if (paren_in != '0) begin
         rsp_code_in = ERR_OPEN_PAREN;
      end else if (brack_in != '0) begin
         rsp_code_in = ERR_OPEN_BRACKET;
      end else begin
         rsp_code_in = ERR_NONE;
         rsp_line_in = '0;
         rsp_col_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (req_take && req_last)) begin
         mode_ff   <= MODE_NORMAL;
         pend_ff   <= PEND_NONE;
         paren_ff  <= '0;
         brace_ff  <= '0;
         brack_ff  <= '0;
         cdepth_ff <= '0;
         line_ff   <= POS_ONE;
         col_ff    <= POS_ONE;
         err_ff    <= ERR_NONE;
         eline_ff  <= '0;
         ecol_ff   <= '0;
      end else if (req_take) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         paren_ff  <= paren_in;
         brace_ff  <= brace_in;
         brack_ff  <= brack_in;
         cdepth_ff <= cdepth_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         err_ff    <= err_in;
         eline_ff  <= eline_in;
         ecol_ff   <= ecol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && req_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_last) begin
         rsp_code_ff <= rsp_code_in;
         rsp_line_ff <= rsp_line_in;
         rsp_col_ff  <= rsp_col_in;
      end
   end

   assign line_wide      = WIDE_BITS'(rsp_line_ff);
   assign col_wide       = WIDE_BITS'(rsp_col_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = (rsp_code_ff == ERR_NONE);
   assign rsp_error_code = rsp_code_ff;
   assign rsp_line       = line_wide[OUT_POS_BITS-1:0];
   assign rsp_column     = col_wide[OUT_POS_BITS-1:0];

endmodule
